// ----- rtl/pfsa_pkg.sv -----
`default_nettype none

package pfsa_pkg;

  localparam int unsigned StackDepthDef = 65536;
  localparam int unsigned PageBytesDef  = 4096;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned FreedW  = 17;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [AddrW-1:0] KernelEndRst  = 32'h0000_0000;
  localparam logic [AddrW-1:0] KernelBaseRst = 32'h8000_0000;
  localparam logic [AddrW-1:0] PhysLimitRst  = 32'h0E00_0000;

  typedef enum logic [1:0] {
    CMD_FREE  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_RANGE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BAD   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KERNEL_END  = 2'd0,
    CFG_KERNEL_BASE = 2'd1,
    CFG_PHYS_LIMIT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_RANGE
  } state_e;

  typedef struct packed {
    logic [AddrW-1:0] kernel_end;
    logic [AddrW-1:0] kernel_base;
    logic [AddrW-1:0] phys_limit;
  } cfg_t;

  typedef struct packed {
    logic bad;
    logic full;
  } page_chk_t;

endpackage

`default_nettype wire

// ----- rtl/pfsa_stack_mem.sv -----
`default_nettype none

module pfsa_stack_mem #(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = 16,
  parameter int unsigned DATA_W = 20
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/pfsa_page_chk.sv -----
`default_nettype none

module pfsa_page_chk
  import pfsa_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef,
  parameter int unsigned PG_W        = 12,
  parameter int unsigned CNT_W       = 17
) (
  input  wire logic [AddrW-1:0] addr_i,
  input  wire cfg_t             cfg_i,
  input  wire logic [CNT_W-1:0] count_i,
  output page_chk_t             chk_o
);

  logic [AddrW-1:0] phys;

  assign phys = addr_i - cfg_i.kernel_base;

  always_comb begin
    chk_o.bad  = (|addr_i[PG_W-1:0]) || (addr_i < cfg_i.kernel_end) ||
                 (phys >= cfg_i.phys_limit);
    chk_o.full = (count_i >= CNT_W'(STACK_DEPTH));
  end

endmodule

`default_nettype wire

// ----- rtl/page_frame_stack_allocator.sv -----
`default_nettype none

// free page frame stack allocator
//
// command channel: command_i, address_i and range_end_i are taken at a clock
// edge with start_i high and busy_o low. each command gives exactly one result
// beat on page_address_o, status_o and pages_freed_o, marked by done_o for a
// single cycle; the receiver has no way to stall it.
// config channel: cfg_valid_i with cfg_index_i / cfg_data_i, cfg_ready_o is
// always high; write only while no command is in flight.
// per command:
//   free one page - result in the cycle after the beat, busy_o stays low so a
//                   new command can follow back to back
//   allocate      - a memory read of the stack top, then the result; on an
//                   empty stack the result comes in the next cycle
//   free a range  - pushes the pages one by one, then gives the result
//   unused code   - result of all zeros in the next cycle
// the free stack sits in a single-port-write, single-port-read memory with
// a registered read; only entries below the fill count are ever read, so the
// memory needs no clearing after reset. reset clears the fill count, the
// config registers to their defaults and the control state; a command can be
// issued in the first cycle after reset is released.

module page_frame_stack_allocator
  import pfsa_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef,
  parameter int unsigned PAGE_BYTES  = PageBytesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // command channel
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         command_i,
  input  wire logic [AddrW-1:0]   address_i,
  input  wire logic [AddrW-1:0]   range_end_i,
  // result channel
  output logic                    done_o,
  output logic      [AddrW-1:0]   page_address_o,
  output logic      [1:0]         status_o,
  output logic      [FreedW-1:0]  pages_freed_o,
  // config channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [AddrW-1:0]   cfg_data_i
);

  localparam int unsigned PgW   = $clog2(PAGE_BYTES);
  localparam int unsigned FnW   = AddrW - PgW;            // frame number width
  localparam int unsigned MemAw = $clog2(STACK_DEPTH);
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

  // config registers
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kernel_end  <= KernelEndRst;
      cfg_q.kernel_base <= KernelBaseRst;
      cfg_q.phys_limit  <= PhysLimitRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KERNEL_END:  cfg_q.kernel_end  <= cfg_data_i;
        CFG_KERNEL_BASE: cfg_q.kernel_base <= cfg_data_i;
        CFG_PHYS_LIMIT:  cfg_q.phys_limit  <= cfg_data_i;
        default: ;                                        // unused index, dropped
      endcase
    end
  end

  // control and datapath state
  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  freed_q, freed_d;
  logic [FnW:0]     frame_q, frame_d;                     // one extra bit: rounding may carry
  logic [FnW-1:0]   rend_q, rend_d;                       // last frame bound of the range

  logic             done_q, done_d;
  logic [AddrW-1:0] page_q, page_d;
  status_e          status_q, status_d;
  logic [CntW-1:0]  pfreed_q, pfreed_d;

  // stack memory port signals
  logic             mem_we, mem_re;
  logic [MemAw-1:0] mem_waddr, mem_raddr;
  logic [FnW-1:0]   mem_wdata, mem_rdata;

  // shared page checker
  logic [AddrW-1:0] chk_addr;
  page_chk_t        chk;
  logic [CntW-1:0]  count_dec;
  logic [FnW:0]     frame_start;

  assign count_dec   = count_q - CntW'(1);
  assign frame_start = {1'b0, address_i[AddrW-1:PgW]} + (FnW+1)'(|address_i[PgW-1:0]);

  // in a range walk the checked page is the current frame, otherwise the input
  assign chk_addr = (state_q == S_RANGE) ? {frame_q[FnW-1:0], {PgW{1'b0}}} : address_i;

  pfsa_page_chk #(
    .STACK_DEPTH (STACK_DEPTH),
    .PG_W        (PgW),
    .CNT_W       (CntW)
  ) u_chk (
    .addr_i  (chk_addr),
    .cfg_i   (cfg_q),
    .count_i (count_q),
    .chk_o   (chk)
  );

  pfsa_stack_mem #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (MemAw),
    .DATA_W (FnW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // pushes always land at the fill count, pops read one below it
  assign mem_waddr = count_q[MemAw-1:0];
  assign mem_wdata = chk_addr[AddrW-1:PgW];
  assign mem_raddr = count_dec[MemAw-1:0];

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    freed_d  = freed_q;
    frame_d  = frame_q;
    rend_d   = rend_q;
    done_d   = 1'b0;
    page_d   = page_q;
    status_d = status_q;
    pfreed_d = pfreed_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (command_i)
            CMD_FREE: begin
              done_d   = 1'b1;
              page_d   = '0;
              pfreed_d = '0;
              if (chk.bad) begin
                status_d = STAT_BAD;
              end else if (chk.full) begin
                status_d = STAT_FULL;
              end else begin
                status_d = STAT_OK;
                pfreed_d = CntW'(1);
                mem_we   = 1'b1;
                count_d  = count_q + CntW'(1);
              end
            end
            CMD_ALLOC: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                page_d   = '0;
                status_d = STAT_EMPTY;
                pfreed_d = '0;
              end else begin
                mem_re  = 1'b1;
                count_d = count_dec;
                state_d = S_POP;
              end
            end
            CMD_RANGE: begin
              frame_d = frame_start;
              rend_d  = range_end_i[AddrW-1:PgW];
              freed_d = '0;
              state_d = S_RANGE;
            end
            default: begin
              // unused code: zero result, no state change
              done_d   = 1'b1;
              page_d   = '0;
              status_d = STAT_OK;
              pfreed_d = '0;
            end
          endcase
        end
      end

      S_POP: begin
        done_d   = 1'b1;
        page_d   = {mem_rdata, {PgW{1'b0}}};
        status_d = STAT_OK;
        pfreed_d = '0;
        state_d  = S_IDLE;
      end

      S_RANGE: begin
        // whole page fits below the end while frame < end frame
        if (frame_q >= {1'b0, rend_q}) begin
          done_d   = 1'b1;
          page_d   = '0;
          status_d = STAT_OK;
          pfreed_d = freed_q;
          state_d  = S_IDLE;
        end else if (chk.bad || chk.full) begin
          done_d   = 1'b1;
          page_d   = '0;
          if (chk.bad) begin
            status_d = STAT_BAD;
          end else begin
            status_d = STAT_FULL;
          end
          pfreed_d = freed_q;
          state_d  = S_IDLE;
        end else begin
          mem_we  = 1'b1;
          count_d = count_q + CntW'(1);
          freed_d = freed_q + CntW'(1);
          frame_d = frame_q + (FnW+1)'(1);
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    freed_q  <= freed_d;
    frame_q  <= frame_d;
    rend_q   <= rend_d;
    page_q   <= page_d;
    status_q <= status_d;
    pfreed_q <= pfreed_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign page_address_o = page_q;
  assign status_o       = status_q;
  assign pages_freed_o  = FreedW'(pfreed_q);

endmodule

`default_nettype wire
